// ===== hw/rtl/psev_pkg.sv =====
// ----------------------------------------------------------------------------
// psev_pkg
// Shared types and constants of the postfix stack evaluator: item and result
// layouts, character codes, status codes and the controller/datapath link.
// ----------------------------------------------------------------------------
package psev_pkg;

  // stack geometry
  localparam int STACK_DEPTH = 128;
  localparam int PTR_W       = $clog2(STACK_DEPTH);
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int DATA_W      = 32;
  localparam int DIV_CNT_W   = $clog2(DATA_W + 1);

  // character codes
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = CH_ZERO + 8'd9;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;

  // result status, first error wins
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_UNDERFLOW = 2'd1,
    ST_OVERFLOW  = 2'd2,
    ST_DIVZERO   = 2'd3
  } status_t;

  // input item
  typedef struct packed {
    logic [7:0] character;
    logic       end_of_expression;
  } in_t;

  // result item
  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic [1:0]               status;
  } out_t;

  // controller to datapath commands
  typedef struct packed {
    logic    load_in;
    logic    push_digit;
    logic    rd_ops;
    logic    alu_go;
    logic    div_start;
    logic    div_take;
    logic    push_res;
    logic    rd_top;
    logic    emit;
    logic    set_err;
    status_t err_code;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic is_digit;
    logic is_op;
    logic is_div;
    logic last;
    logic err_set;
    logic cnt_zero;
    logic cnt_lt2;
    logic cnt_full;
    logic rhs_zero;
    logic div_done;
    logic out_full;
  } stat_t;

endpackage

// ===== hw/rtl/postfix_stack_evaluator_unit.sv =====
// ----------------------------------------------------------------------------
// postfix_stack_evaluator_unit
// Postfix expression evaluator on a 128-entry stack of 32-bit operands.
// ----------------------------------------------------------------------------
// Usage:
//   item channel (item_valid/item_ready/item) carries one character per item;
//   end_of_expression marks the last one. result channel
//   (result_valid/result_ready/result) carries one item per expression with
//   the popped top of stack and a status (0 ok, 1 underflow, 2 overflow,
//   3 divide by zero; value is zero on any error).
// Timing: one item in flight at a time, item_ready is high only while idle.
//   digit or ignored character: decode only; + - *: two-port stack read, ALU
//   result register, write back; /: two-port stack read, then the 32-step
//   bit-serial divider and write back. The last item adds the final stack
//   read and the result register load.
// Reset: stack empty and status ok; the stack memory itself is not cleared.
// Stall: the result register holds its item until taken; the next expression
//   runs meanwhile and only waits at its own result if the register is full.
// ----------------------------------------------------------------------------
module postfix_stack_evaluator_unit (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_ready,
  input  psev_pkg::in_t     item,
  output logic              result_valid,
  input  logic              result_ready,
  output psev_pkg::out_t    result
);
  import psev_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // sequencer
  psev_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .result_ready (result_ready),
    .stat         (stat),
    .cmd          (cmd)
  );

  // stack, arithmetic and result register
  psev_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .item         (item),
    .cmd          (cmd),
    .stat         (stat),
    .result       (result),
    .result_valid (result_valid),
    .result_ready (result_ready)
  );

endmodule

// ===== hw/rtl/psev_ctrl.sv =====
// ----------------------------------------------------------------------------
// psev_ctrl
// Sequencer of the evaluator: walks one item through decode, operand read,
// arithmetic, write back and the end-of-expression pop and result.
// ----------------------------------------------------------------------------
module psev_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  output logic                 item_ready,
  input  logic                 result_ready,
  input  psev_pkg::stat_t      stat,
  output psev_pkg::cmd_t       cmd
);
  import psev_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_READ,
    S_DIV,
    S_WRITE,
    S_LAST,
    S_POPRD,
    S_EMIT
  } state_t;

  state_t state;
  state_t state_next;

  // next state and commands
  always_comb begin
    state_next   = state;
    cmd          = '0;
    cmd.err_code = ST_OK;
    item_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        item_ready = 1'b1;
        if (item_valid) begin
          cmd.load_in = 1'b1;
          state_next  = S_DECODE;
        end
      end
      S_DECODE: begin
        state_next = S_LAST;
        if (!stat.err_set) begin
          if (stat.is_digit) begin
            if (stat.cnt_full) begin
              cmd.set_err  = 1'b1;
              cmd.err_code = ST_OVERFLOW;
            end else begin
              cmd.push_digit = 1'b1;
            end
          end else if (stat.is_op) begin
            if (stat.cnt_lt2) begin
              cmd.set_err  = 1'b1;
              cmd.err_code = ST_UNDERFLOW;
            end else begin
              cmd.rd_ops = 1'b1;
              state_next = S_READ;
            end
          end
        end
      end
      S_READ: begin
        if (stat.is_div) begin
          if (stat.rhs_zero) begin
            cmd.set_err  = 1'b1;
            cmd.err_code = ST_DIVZERO;
            state_next   = S_LAST;
          end else begin
            cmd.div_start = 1'b1;
            state_next    = S_DIV;
          end
        end else begin
          cmd.alu_go = 1'b1;
          state_next = S_WRITE;
        end
      end
      S_DIV: begin
        if (stat.div_done) begin
          cmd.div_take = 1'b1;
          state_next   = S_WRITE;
        end
      end
      S_WRITE: begin
        cmd.push_res = 1'b1;
        state_next   = S_LAST;
      end
      S_LAST: begin
        if (!stat.last) begin
          state_next = S_IDLE;
        end else if (stat.err_set) begin
          state_next = S_EMIT;
        end else if (stat.cnt_zero) begin
          cmd.set_err  = 1'b1;
          cmd.err_code = ST_UNDERFLOW;
          state_next   = S_EMIT;
        end else begin
          cmd.rd_top = 1'b1;
          state_next = S_POPRD;
        end
      end
      S_POPRD: begin
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (!stat.out_full || result_ready) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== hw/rtl/psev_dp.sv =====
// ----------------------------------------------------------------------------
// psev_dp
// Datapath of the evaluator: item register, operand stack memory with two
// registered read ports, add/subtract/multiply unit, bit-serial divider,
// error register and the result register.
// ----------------------------------------------------------------------------
module psev_dp (
  input  logic                 clk,
  input  logic                 rst,
  input  psev_pkg::in_t        item,
  input  psev_pkg::cmd_t       cmd,
  output psev_pkg::stat_t      stat,
  output psev_pkg::out_t       result,
  output logic                 result_valid,
  input  logic                 result_ready
);
  import psev_pkg::*;

  // item register
  logic [7:0]        ch;
  logic              last;

  // stack state
  logic [DATA_W-1:0] mem [STACK_DEPTH];
  logic [CNT_W-1:0]  cnt;
  logic [CNT_W-1:0]  cnt_m1;
  logic [CNT_W-1:0]  cnt_m2;
  status_t           err;
  logic [DATA_W-1:0] rd_hi;
  logic [DATA_W-1:0] rd_lo;
  logic [DATA_W-1:0] res;

  // write port
  logic              wr_en;
  logic [PTR_W-1:0]  wr_addr;
  logic [DATA_W-1:0] wr_data;

  // divider
  logic                 div_run;
  logic [DIV_CNT_W-1:0] div_cnt;
  logic [DATA_W-1:0]    div_rem;
  logic [DATA_W-1:0]    div_quo;
  logic [DATA_W-1:0]    div_mb;
  logic                 div_neg;
  logic [DATA_W:0]      div_shift;
  logic                 div_ge;

  // character decode
  logic is_digit;
  logic is_op;

  assign is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
  assign is_op    = (ch == CH_PLUS) || (ch == CH_MINUS) ||
                    (ch == CH_STAR) || (ch == CH_SLASH);

  assign cnt_m1 = cnt - CNT_W'(1);
  assign cnt_m2 = cnt - CNT_W'(2);

  // status to the controller
  always_comb begin
    stat.is_digit = is_digit;
    stat.is_op    = is_op;
    stat.is_div   = (ch == CH_SLASH);
    stat.last     = last;
    stat.err_set  = (err != ST_OK);
    stat.cnt_zero = (cnt == '0);
    stat.cnt_lt2  = (cnt < CNT_W'(2));
    stat.cnt_full = (cnt == CNT_W'(STACK_DEPTH));
    stat.rhs_zero = (rd_hi == '0);
    stat.div_done = div_run && (div_cnt == '0);
    stat.out_full = result_valid;
  end

  // latch the accepted item
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      ch   <= item.character;
      last <= item.end_of_expression;
    end
  end

  // write port select: digit push or operator result
  always_comb begin
    wr_en   = cmd.push_digit || cmd.push_res;
    wr_addr = cnt[PTR_W-1:0];
    wr_data = DATA_W'(ch - CH_ZERO);
    if (cmd.push_res) begin
      wr_addr = cnt_m2[PTR_W-1:0];
      wr_data = res;
    end
  end

  // operand stack memory, one write and two registered reads
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_ops || cmd.rd_top) begin
      rd_hi <= mem[cnt_m1[PTR_W-1:0]];
    end
    if (cmd.rd_ops) begin
      rd_lo <= mem[cnt_m2[PTR_W-1:0]];
    end
  end

  // stack count and sticky error
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      err <= ST_OK;
    end else if (cmd.emit) begin
      cnt <= '0;
      err <= ST_OK;
    end else begin
      if (cmd.push_digit) begin
        cnt <= cnt + CNT_W'(1);
      end else if (cmd.push_res) begin
        cnt <= cnt_m1;
      end
      if (cmd.set_err && (err == ST_OK)) begin
        err <= cmd.err_code;
      end
    end
  end

  // arithmetic result register
  always_ff @(posedge clk) begin
    if (cmd.alu_go) begin
      case (ch)
        CH_PLUS:  res <= rd_lo + rd_hi;
        CH_MINUS: res <= rd_lo - rd_hi;
        default:  res <= DATA_W'(rd_lo * rd_hi);
      endcase
    end else if (cmd.div_take) begin
      res <= div_neg ? (DATA_W'(0) - div_quo) : div_quo;
    end
  end

  // restoring divider step on magnitudes
  assign div_shift = {div_rem, div_quo[DATA_W-1]};
  assign div_ge    = (div_shift >= {1'b0, div_mb});

  always_ff @(posedge clk) begin
    if (rst) begin
      div_run <= 1'b0;
      div_cnt <= '0;
    end else if (cmd.div_start) begin
      div_run <= 1'b1;
      div_cnt <= DIV_CNT_W'(DATA_W);
    end else if (cmd.div_take) begin
      div_run <= 1'b0;
    end else if (div_run && (div_cnt != '0)) begin
      div_cnt <= div_cnt - DIV_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      div_rem <= '0;
      div_quo <= rd_lo[DATA_W-1] ? (DATA_W'(0) - rd_lo) : rd_lo;
      div_mb  <= rd_hi[DATA_W-1] ? (DATA_W'(0) - rd_hi) : rd_hi;
      div_neg <= rd_lo[DATA_W-1] ^ rd_hi[DATA_W-1];
    end else if (div_run && (div_cnt != '0)) begin
      div_rem <= div_ge ? DATA_W'(div_shift - {1'b0, div_mb}) : div_shift[DATA_W-1:0];
      div_quo <= {div_quo[DATA_W-2:0], div_ge};
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.emit) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      result.value  <= (err != ST_OK) ? '0 : $signed(rd_hi);
      result.status <= err;
    end
  end

  // checks
  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_W'(STACK_DEPTH))
    else $error("stack count beyond depth");

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    cmd.push_digit |-> (cnt < CNT_W'(STACK_DEPTH)))
    else $error("digit pushed onto a full stack");

  a_emit_clears: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> (cnt == '0) && (err == ST_OK) && result_valid)
    else $error("stack not cleared after result");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && (result.status != ST_OK)) |-> (result.value == '0))
    else $error("nonzero value with error status");

endmodule

// ===== bench/tb_postfix_stack_evaluator_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_postfix_stack_evaluator_unit
// Self-checking bench for the postfix evaluator. A short scripted sequence
// covers the extreme characters, every operator, truncating division, divide
// by zero, underflow and sticky errors. Random expressions follow: well-formed
// ones with random content, loose operator/digit strings, byte noise, a
// full-depth and an overflowing stack, and the most negative value divided by
// minus one. Every item goes through an internal stack predictor. Results are
// compared field by field in order under several sender and receiver pacing
// mixes, with one long receiver hold that backs the block up.
// ----------------------------------------------------------------------------
module tb_postfix_stack_evaluator_unit;
  import psev_pkg::*;

  localparam int PHASE_ITEMS = 125;
  localparam int HOLD_CYCLES = 1500;
  localparam int TAIL_CYCLES = 60;

  // scripted row: item, and the result typed in where it is obvious
  typedef struct packed {
    in_t  stim;
    logic typed;
    out_t want;
  } row_t;

  localparam row_t SCRIPT [25] = '{
    '{'{8'h00, 1'b1}, 1'b1, '{32'sd0, ST_UNDERFLOW}},        // empty pop after reset
    '{'{CH_NINE, 1'b1}, 1'b1, '{32'sd9, ST_OK}},
    '{'{CH_ZERO, 1'b1}, 1'b1, '{32'sd0, ST_OK}},
    '{'{CH_ZERO + 8'd7, 1'b0}, 1'b0, '{32'sd0, ST_OK}},
    '{'{CH_ZERO + 8'd5, 1'b0}, 1'b0, '{32'sd0, ST_OK}},
    '{'{CH_MINUS, 1'b1}, 1'b0, '{32'sd0, ST_OK}},             // operator on last item
    '{'{CH_NINE, 1'b0}, 1'b0, '{32'sd0, ST_OK}},
    '{'{CH_NINE, 1'b0}, 1'b0, '{32'sd0, ST_OK}},
    '{'{8'hFF, 1'b0}, 1'b0, '{32'sd0, ST_OK}},
    '{'{CH_PLUS, 1'b1}, 1'b0, '{32'sd0, ST_OK}},
    '{'{CH_ZERO + 8'd3, 1'b0}, 1'b0, '{32'sd0, ST_OK}},
    '{'{CH_ZERO + 8'd4, 1'b0}, 1'b0, '{32'sd0, ST_OK}},
    '{'{CH_STAR, 1'b1}, 1'b0, '{32'sd0, ST_OK}},
    '{'{CH_ZERO, 1'b0}, 1'b0, '{32'sd0, ST_OK}},
    '{'{CH_ZERO + 8'd7, 1'b0}, 1'b0, '{32'sd0, ST_OK}},
    '{'{CH_MINUS, 1'b0}, 1'b0, '{32'sd0, ST_OK}},
    '{'{CH_ZERO + 8'd2, 1'b0}, 1'b0, '{32'sd0, ST_OK}},
    '{'{CH_SLASH, 1'b1}, 1'b0, '{32'sd0, ST_OK}},             // negative quotient
    '{'{CH_ZERO + 8'd5, 1'b0}, 1'b0, '{32'sd0, ST_OK}},
    '{'{CH_ZERO, 1'b0}, 1'b0, '{32'sd0, ST_OK}},
    '{'{CH_SLASH, 1'b1}, 1'b1, '{32'sd0, ST_DIVZERO}},
    '{'{CH_PLUS, 1'b0}, 1'b0, '{32'sd0, ST_OK}},              // underflow, then sticky
    '{'{CH_NINE, 1'b1}, 1'b1, '{32'sd0, ST_UNDERFLOW}},
    '{'{CH_NINE, 1'b0}, 1'b0, '{32'sd0, ST_OK}},
    '{'{CH_PLUS, 1'b1}, 1'b1, '{32'sd0, ST_UNDERFLOW}}        // one operand only
  };

  logic clk = 1'b0;
  logic rst;
  logic item_valid;
  logic item_ready;
  in_t  item;
  logic result_valid;
  logic result_ready = 1'b0;
  out_t result;

  // pacing and pressure controls
  int   idle_pct  = 0;
  int   stall_pct = 0;
  logic hold_go   = 1'b0;
  logic hold_rx   = 1'b0;

  // predictor state
  logic [31:0] operands [STACK_DEPTH];
  int          depth = 0;
  status_t     first_err = ST_OK;

  out_t        expr_results_q [$];
  logic [7:0]  expr_buf [$];
  int          mismatches   = 0;
  int          active_items = 0;

  postfix_stack_evaluator_unit dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // character classes
  function automatic bit is_digit(logic [7:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  function automatic bit is_oper(logic [7:0] c);
    return c == CH_PLUS || c == CH_MINUS || c == CH_STAR || c == CH_SLASH;
  endfunction

  // predictor: first error is kept
  function automatic void raise_err(status_t s);
    if (first_err == ST_OK) first_err = s;
  endfunction

  function automatic void push_operand(logic [31:0] v);
    if (depth >= STACK_DEPTH) begin
      raise_err(ST_OVERFLOW);
    end else begin
      operands[depth] = v;
      depth++;
    end
  endfunction

  // signed divide, quotient truncated toward zero
  function automatic logic [31:0] trunc_quotient(logic [31:0] a, logic [31:0] b);
    logic [31:0] ma, mb, q;
    ma = a[31] ? 32'd0 - a : a;
    mb = b[31] ? 32'd0 - b : b;
    q  = ma / mb;
    return (a[31] != b[31]) ? 32'd0 - q : q;
  endfunction

  function automatic void apply_char(logic [7:0] c);
    logic [31:0] lhs, rhs, res;
    if (is_digit(c)) begin
      push_operand({24'd0, c - CH_ZERO});
      return;
    end
    if (!is_oper(c)) return;
    if (depth < 2) begin
      raise_err(ST_UNDERFLOW);
      return;
    end
    rhs = operands[depth-1];
    lhs = operands[depth-2];
    depth -= 2;
    unique case (c)
      CH_PLUS:  res = lhs + rhs;
      CH_MINUS: res = lhs - rhs;
      CH_STAR:  res = lhs * rhs;
      default: begin
        if (rhs == 32'd0) begin
          raise_err(ST_DIVZERO);
          return;
        end
        res = trunc_quotient(lhs, rhs);
      end
    endcase
    push_operand(res);
  endfunction

  function automatic void eval_item(in_t it);
    out_t r;
    if (first_err == ST_OK) apply_char(it.character);
    if (!it.end_of_expression) return;
    r.value = '0;
    if (first_err == ST_OK) begin
      if (depth == 0) begin
        raise_err(ST_UNDERFLOW);
      end else begin
        depth--;
        r.value = operands[depth];
      end
    end
    if (first_err != ST_OK) r.value = '0;
    r.status = first_err;
    expr_results_q.push_back(r);
    depth     = 0;
    first_err = ST_OK;
  endfunction

  // expression builders, characters collect in expr_buf
  function automatic logic [7:0] pick_oper();
    unique case ($urandom_range(0, 3))
      0:       return CH_PLUS;
      1:       return CH_MINUS;
      2:       return CH_STAR;
      default: return CH_SLASH;
    endcase
  endfunction

  function automatic logic [7:0] pick_ignored();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (is_digit(c) || is_oper(c));
    return c;
  endfunction

  function automatic logic [7:0] pick_digit();
    return CH_ZERO + 8'($urandom_range(0, 9));
  endfunction

  // valid postfix with random content and stray ignored characters
  function automatic void build_valid(int n_ops, int max_depth);
    int d, digits_left, ops_left;
    d           = 0;
    digits_left = n_ops + 1;
    ops_left    = n_ops;
    while (digits_left > 0 || ops_left > 0) begin
      if ($urandom_range(0, 7) == 0) expr_buf.push_back(pick_ignored());
      if (digits_left > 0 &&
          (d < 2 || ops_left == 0 || (d < max_depth && $urandom_range(0, 1) == 1))) begin
        expr_buf.push_back(pick_digit());
        digits_left--;
        d++;
      end else begin
        expr_buf.push_back(pick_oper());
        ops_left--;
        d--;
      end
    end
    if ($urandom_range(0, 5) == 0) expr_buf.push_back(pick_ignored());
  endfunction

  // digits and operators in any order, mostly ending in errors
  function automatic void build_loose(int len);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 9) == 0)      expr_buf.push_back(pick_ignored());
      else if ($urandom_range(0, 1) == 0) expr_buf.push_back(pick_digit());
      else                                expr_buf.push_back(pick_oper());
    end
  endfunction

  function automatic void build_noise(int len);
    for (int i = 0; i < len; i++) expr_buf.push_back(8'($urandom_range(0, 255)));
  endfunction

  function automatic void build_digits(int n);
    for (int i = 0; i < n; i++) expr_buf.push_back(pick_digit());
  endfunction

  // 8^10 * 2 is the most negative value, then divided by 0 - 1
  function automatic void build_min_quotient();
    expr_buf.push_back(CH_ZERO + 8'd8);
    for (int i = 0; i < 9; i++) begin
      expr_buf.push_back(CH_ZERO + 8'd8);
      expr_buf.push_back(CH_STAR);
    end
    expr_buf.push_back(CH_ZERO + 8'd2);
    expr_buf.push_back(CH_STAR);
    expr_buf.push_back(CH_ZERO);
    expr_buf.push_back(CH_ZERO + 8'd1);
    expr_buf.push_back(CH_MINUS);
    expr_buf.push_back(CH_SLASH);
  endfunction

  // item channel driver
  task automatic send_item(input in_t it);
    while ($urandom_range(0, 99) < idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    item       <= it;
    do @(posedge clk); while (!item_ready);
    eval_item(it);
    active_items++;
  endtask

  task automatic send_expr();
    for (int i = 0; i < expr_buf.size(); i++)
      send_item('{character: expr_buf[i], end_of_expression: i == expr_buf.size() - 1});
    expr_buf.delete();
  endtask

  task automatic wait_results();
    item_valid <= 1'b0;
    while (expr_results_q.size() != 0) @(posedge clk);
  endtask

  // main stimulus
  initial begin
    int sel;
    rst        <= 1'b1;
    item_valid <= 1'b0;
    item       <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // scripted part
    foreach (SCRIPT[i]) begin
      send_item(SCRIPT[i].stim);
      if (SCRIPT[i].typed) expr_results_q[expr_results_q.size() - 1] = SCRIPT[i].want;
    end
    wait_results();

    // random part, one pacing mix per phase
    for (int phase = 0; phase < 4; phase++) begin
      unique case (phase)
        0: begin idle_pct = 0;  stall_pct <= 0;  end
        1: begin idle_pct = 86; stall_pct <= 0;  end
        2: begin idle_pct = 0;  stall_pct <= 86; end
        default: begin idle_pct = 22; stall_pct <= 22; end
      endcase
      if (phase == 0) begin
        hold_go <= 1'b1;
        build_digits(STACK_DEPTH);
        send_expr();
        build_digits(STACK_DEPTH + 2);
        send_expr();
        build_min_quotient();
        send_expr();
      end
      active_items = 0;
      while (active_items < PHASE_ITEMS) begin
        sel = $urandom_range(0, 99);
        if (sel < 55)      build_valid($urandom_range(0, 10), 6);
        else if (sel < 65) build_valid($urandom_range(10, 40), 20);
        else if (sel < 85) build_loose($urandom_range(1, 10));
        else               build_noise($urandom_range(1, 6));
        send_expr();
      end
      wait_results();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

  // long receiver hold while the sender keeps going
  initial begin : long_hold
    do @(posedge clk); while (!hold_go);
    hold_rx <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_rx <= 1'b0;
  end

  // result channel: random stalls and in-order compare
  always @(posedge clk) begin : result_check
    out_t want;
    if (rst) begin
      result_ready <= 1'b0;
    end else begin
      if (result_valid && result_ready) begin
        if (expr_results_q.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result, expected none actual value %0d status %0d",
                   $time, result.value, result.status);
        end else begin
          want = expr_results_q.pop_front();
          if (result.value !== want.value) begin
            mismatches++;
            $display("%0t: value mismatch, expected %0d actual %0d",
                     $time, want.value, result.value);
          end
          if (result.status !== want.status) begin
            mismatches++;
            $display("%0t: status mismatch, expected %0d actual %0d",
                     $time, want.status, result.status);
          end
        end
      end
      result_ready <= !hold_rx && ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // watchdog
  initial begin
    #5_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/psev_pkg.sv
hw/rtl/psev_ctrl.sv
hw/rtl/psev_dp.sv
hw/rtl/postfix_stack_evaluator_unit.sv
bench/tb_postfix_stack_evaluator_unit.sv
